FILE: hw/rtl/cmpr_pkg.sv
package cmpr_pkg;

    localparam int CMPR_CLASSES    = 16;
    localparam int CMPR_COUNT_BITS = 20;
    localparam int CMPR_FRAC_BITS  = 16;
    localparam int CMPR_NC_BITS    = 5;
    localparam int CMPR_IDX_BITS   = 4;

endpackage

FILE: hw/rtl/cmpr_div.sv
// Restoring divider, one quotient bit per cycle: q = num / den, den != 0
module cmpr_div import cmpr_pkg::*; #(
    parameter int NUM_BITS = 48,
    parameter int DEN_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                busy,
    output logic [NUM_BITS-1:0] quo
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] q_reg, q_next;
    logic [DEN_BITS:0]   r_reg, r_next;
    logic [DEN_BITS-1:0] d_reg;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [DEN_BITS:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = '0;
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial  = {r_reg[DEN_BITS-1:0], q_reg[NUM_BITS-1]};
            q_next = {q_reg[NUM_BITS-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                r_next    = trial - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            else
            begin
                r_next = trial;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            d_reg <= den;
        end
    end

    assign busy = busy_reg;
    assign quo  = q_reg;
endmodule

FILE: hw/rtl/confusion_matrix_precision_recall.sv
// Channel   Direction  Handshake        Payload
// in        input      in_valid/stall   true_class, pred_class, last_sample
// out       output     out_valid/stall  class_index .. last_result
// cfg       input      cfg_valid/ready  cfg_data (num_classes)
// Counting: one word per cycle while in_stall is low; the count memory is read at
// acceptance, the new count is registered in s2 and written from there, forwarded from
// the two most recent writes. Emission: per class 2*N reads, then up to two divisions
// (precision, recall); the summary adds up to three more. Then a clearing pass over all
// CLASSES*CLASSES words, as after reset; in_stall stays high from the last word until it
// ends. Results wait in an output register under out_stall.
module confusion_matrix_precision_recall import cmpr_pkg::*; #(
    parameter int CLASSES    = CMPR_CLASSES,
    parameter int COUNT_BITS = CMPR_COUNT_BITS,
    parameter int FRAC_BITS  = CMPR_FRAC_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [CMPR_IDX_BITS-1:0]  true_class,
    input  logic [CMPR_IDX_BITS-1:0]  pred_class,
    input  logic                      last_sample,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CMPR_NC_BITS-1:0]   cfg_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [CMPR_IDX_BITS-1:0]  class_index,
    output logic                      is_summary,
    output logic [FRAC_BITS:0]        precision_q16,
    output logic                      precision_valid,
    output logic [FRAC_BITS:0]        recall_q16,
    output logic                      recall_valid,
    output logic [FRAC_BITS:0]        fscore_q16,
    output logic                      fscore_valid,
    output logic                      last_result
);
    localparam int CB    = (CLASSES > 2) ? $clog2(CLASSES) : 1;
    localparam int ADR_B = 2 * CB;
    localparam int DEPTH = CLASSES * CLASSES;
    localparam int SUM_B = COUNT_BITS + ADR_B;        // row/column sum
    localparam int NUM_B = SUM_B + FRAC_BITS + 2;     // dividend width
    localparam int ACC_B = FRAC_BITS + 1 + CB + 1;    // sum of per-class ratios
    localparam int CNT_B = CB + 1;
    localparam int PRD_B = 2 * FRAC_BITS + 3;         // 2 * P * R
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_RUN  = 9'b000000010,
        S_SUM  = 9'b000000100,
        S_DIVP = 9'b000001000,
        S_DIVR = 9'b000010000,
        S_OUT  = 9'b000100000,
        S_AVGP = 9'b001000000,
        S_AVGR = 9'b010000000,
        S_FSC  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // count memory
    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] rd_data;
    logic [ADR_B-1:0]      rd_adr;
    logic                  wr_en;
    logic [ADR_B-1:0]      wr_adr;
    logic [COUNT_BITS-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_adr] <= wr_data;
        end
        rd_data <= mem[rd_adr];
    end

    logic [CMPR_NC_BITS-1:0] nc_reg;
    logic [CNT_B-1:0]        n_eff;
    always_comb
    begin
        if (nc_reg < CMPR_NC_BITS'(2))
            n_eff = CNT_B'(2);
        else if (32'(nc_reg) > CLASSES)
            n_eff = CNT_B'(CLASSES);
        else
            n_eff = CNT_B'(nc_reg);
    end

    // counting pipeline: s1 = read issued, s2 = data back, write; s3 = last write
    logic             s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [ADR_B-1:0] s1_adr_reg, s2_adr_reg, s3_adr_reg;
    logic             s1_last_reg;
    logic [COUNT_BITS-1:0] s2_val_reg, s3_val_reg, cur_cnt;

    logic in_acc, in_ok;
    logic [CB-1:0] tc, pc;
    assign tc     = CB'(true_class);
    assign pc     = CB'(pred_class);
    assign in_ok  = ({1'b0, true_class} < 5'(n_eff)) && ({1'b0, pred_class} < 5'(n_eff));
    assign in_acc = in_valid && !in_stall;

    // the write at the last edge is not yet seen by the read issued at that edge
    assign cur_cnt = (s2_vld_reg && s2_adr_reg == s1_adr_reg) ? s2_val_reg :
                     (s3_vld_reg && s3_adr_reg == s1_adr_reg) ? s3_val_reg : rd_data;

    // emission bookkeeping
    logic [CB-1:0]    cls_reg, cls_next;
    logic [CNT_B-1:0] j_reg, j_next;
    logic             phase_reg, phase_next;  // 0 issue reads, 1 drain
    logic             rdv_reg;
    logic             rdcol_reg;              // the returning word is a column word
    logic             rddiag_reg;
    logic [SUM_B-1:0] col_reg, row_reg, col_next, row_next;
    logic [COUNT_BITS-1:0] diag_reg, diag_next;
    logic [ACC_B-1:0] psum_reg, rsum_reg, psum_next, rsum_next;
    logic [CNT_B-1:0] pdef_reg, rdef_reg, pdef_next, rdef_next;
    logic [FRAC_BITS:0] pq_reg, rq_reg, pq_next, rq_next;
    logic             pv_reg, rv_reg, pv_next, rv_next;
    logic [ADR_B-1:0] clr_reg, clr_next;
    logic             rd_sel_col;
    logic [CB-1:0]    rd_j;
    logic [PRD_B-1:0] fprod;

    // output register
    logic             ov_reg, ov_next;
    logic [CMPR_IDX_BITS-1:0] oi_reg, oi_next;
    logic             os_reg, os_next, opv_reg, opv_next, orv_reg, orv_next;
    logic             ofv_reg, ofv_next;
    logic [FRAC_BITS:0] op_reg, op_next, or_reg, or_next, of_reg, of_next;

    // divider
    logic             div_start, div_busy;
    logic [NUM_B-1:0] dnum, dquo;
    logic [SUM_B-1:0] dden;

    cmpr_div #(.NUM_BITS(NUM_B), .DEN_BITS(SUM_B)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (dnum),
        .den   (dden),
        .busy  (div_busy),
        .quo   (dquo)
    );

    assign in_stall  = (state_reg != S_RUN) || s1_last_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        rd_sel_col = !j_reg[0];
        rd_j       = CB'(j_reg >> 1);
    end

    // 2 * P * R on the quantized averages
    assign fprod = {pq_reg, 1'b0} * (FRAC_BITS+1)'(dquo);

    always_comb
    begin
        state_next = state_reg;
        cls_next = cls_reg; j_next = j_reg; phase_next = phase_reg;
        col_next = col_reg; row_next = row_reg; diag_next = diag_reg;
        psum_next = psum_reg; rsum_next = rsum_reg;
        pdef_next = pdef_reg; rdef_next = rdef_reg;
        pq_next = pq_reg; rq_next = rq_reg; pv_next = pv_reg; rv_next = rv_reg;
        clr_next = clr_reg;
        ov_next = ov_reg; oi_next = oi_reg; os_next = os_reg;
        op_next = op_reg; opv_next = opv_reg; or_next = or_reg; orv_next = orv_reg;
        of_next = of_reg; ofv_next = ofv_reg;
        wr_en = 1'b0; wr_adr = '0; wr_data = '0;
        rd_adr = {tc, pc};
        div_start = 1'b0;
        dnum = '0; dden = '0;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        // write-back of counting pipeline
        if (s2_vld_reg)
        begin
            wr_en = 1'b1; wr_adr = s2_adr_reg; wr_data = s2_val_reg;
        end

        case (state_reg)
            S_CLR:
            begin
                wr_en = 1'b1; wr_adr = clr_reg; wr_data = '0;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == DEPTH - 1)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                // wait until the last word has been written back
                if (s1_last_reg && !s1_vld_reg && !s2_vld_reg)
                begin
                    state_next = S_SUM; cls_next = '0; j_next = '0; phase_next = 1'b0;
                    col_next = '0; row_next = '0; diag_next = '0;
                    psum_next = '0; rsum_next = '0; pdef_next = '0; rdef_next = '0;
                end
            end
            S_SUM:
            begin
                // issue reads: even j column word (j/2,cls), odd j row word (cls,j/2)
                if (!phase_reg)
                begin
                    rd_adr = rd_sel_col ? {rd_j, cls_reg} : {cls_reg, rd_j};
                    j_next = j_reg + 1'b1;
                    if (rd_j == CB'(n_eff - 1'b1) && !rd_sel_col)
                    begin
                        phase_next = 1'b1;
                    end
                end
                if (rdv_reg)
                begin
                    if (rdcol_reg)
                        col_next = col_reg + SUM_B'(rd_data);
                    else
                        row_next = row_reg + SUM_B'(rd_data);
                    if (rddiag_reg)
                        diag_next = rd_data;
                end
                if (phase_reg && !rdv_reg)
                begin
                    state_next = S_DIVP;
                    pq_next = '0; pv_next = 1'b0;
                    if (col_reg != '0)
                    begin
                        div_start = 1'b1;
                        dnum = NUM_B'({diag_reg, FRAC_BITS'(0)});
                        dden = col_reg;
                        pv_next = 1'b1;
                    end
                end
            end
            S_DIVP:
            begin
                if (!div_busy && !div_start)
                begin
                    if (pv_reg)
                    begin
                        pq_next   = (FRAC_BITS+1)'(dquo);
                        psum_next = psum_reg + ACC_B'((FRAC_BITS+1)'(dquo));
                        pdef_next = pdef_reg + 1'b1;
                    end
                    state_next = S_DIVR;
                    rq_next = '0; rv_next = 1'b0;
                    if (row_reg != '0)
                    begin
                        div_start = 1'b1;
                        dnum = NUM_B'({diag_reg, FRAC_BITS'(0)});
                        dden = row_reg;
                        rv_next = 1'b1;
                    end
                end
            end
            S_DIVR:
            begin
                if (!div_busy && !div_start)
                begin
                    if (rv_reg)
                    begin
                        rq_next   = (FRAC_BITS+1)'(dquo);
                        rsum_next = rsum_reg + ACC_B'((FRAC_BITS+1)'(dquo));
                        rdef_next = rdef_reg + 1'b1;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ov_next)
                begin
                    ov_next = 1'b1; oi_next = CMPR_IDX_BITS'(cls_reg); os_next = 1'b0;
                    op_next = pq_reg; opv_next = pv_reg; or_next = rq_reg; orv_next = rv_reg;
                    of_next = '0; ofv_next = 1'b0;
                    if (CNT_B'(cls_reg) == n_eff - 1'b1)
                    begin
                        state_next = S_AVGP;
                        pq_next = '0; pv_next = 1'b0;
                        if (pdef_reg != '0)
                        begin
                            div_start = 1'b1;
                            dnum = NUM_B'(psum_reg); dden = SUM_B'(pdef_reg);
                            pv_next = 1'b1;
                        end
                    end
                    else
                    begin
                        cls_next = cls_reg + 1'b1; j_next = '0; phase_next = 1'b0;
                        col_next = '0; row_next = '0; diag_next = '0;
                        state_next = S_SUM;
                    end
                end
            end
            S_AVGP:
            begin
                if (!div_busy && !div_start)
                begin
                    if (pv_reg) pq_next = (FRAC_BITS+1)'(dquo);
                    state_next = S_AVGR;
                    rq_next = '0; rv_next = 1'b0;
                    if (rdef_reg != '0)
                    begin
                        div_start = 1'b1;
                        dnum = NUM_B'(rsum_reg); dden = SUM_B'(rdef_reg);
                        rv_next = 1'b1;
                    end
                end
            end
            S_AVGR:
            begin
                if (!div_busy && !div_start)
                begin
                    if (rv_reg) rq_next = (FRAC_BITS+1)'(dquo);
                    state_next = S_FSC;
                    // reuse diag as "fscore defined" marker via divider start
                    diag_next = '0;
                    if (pv_reg && rv_reg && (dquo != '0 || pq_reg != '0))
                    begin
                        div_start = 1'b1;
                        diag_next  = COUNT_BITS'(1);
                        dnum = NUM_B'(fprod);
                        dden = SUM_B'(pq_reg) + SUM_B'((FRAC_BITS+1)'(dquo));
                    end
                end
            end
            S_FSC:
            begin
                if (!div_busy && !div_start && !ov_next)
                begin
                    ov_next = 1'b1; oi_next = '0; os_next = 1'b1;
                    op_next = pq_reg; opv_next = pv_reg; or_next = rq_reg; orv_next = rv_reg;
                    ofv_next = diag_reg[0];
                    of_next  = diag_reg[0] ? (FRAC_BITS+1)'(dquo) : '0;
                    clr_next = '0;
                    state_next = S_CLR;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            nc_reg      <= CMPR_NC_BITS'(2);
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            rdv_reg     <= 1'b0;
            ov_reg      <= 1'b0;
            cls_reg     <= '0;
            j_reg       <= '0;
            phase_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_valid && cfg_ready)
            begin
                nc_reg <= cfg_data;
            end
            s1_vld_reg <= in_acc && in_ok;
            if (in_acc)
                s1_last_reg <= last_sample;
            else if (state_reg != S_RUN)
                s1_last_reg <= 1'b0;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            rdv_reg    <= (state_reg == S_SUM) && !phase_reg;
            ov_reg     <= ov_next;
            cls_reg    <= cls_next;
            j_reg      <= j_next;
            phase_reg  <= phase_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_adr_reg <= {tc, pc};
        s2_adr_reg <= s1_adr_reg;
        s2_val_reg <= (cur_cnt == CMAX) ? cur_cnt : cur_cnt + 1'b1;
        s3_adr_reg <= s2_adr_reg;
        s3_val_reg <= s2_val_reg;
        rdcol_reg  <= rd_sel_col;
        rddiag_reg <= rd_sel_col && (rd_j == cls_reg);
        col_reg <= col_next; row_reg <= row_next; diag_reg <= diag_next;
        psum_reg <= psum_next; rsum_reg <= rsum_next;
        pdef_reg <= pdef_next; rdef_reg <= rdef_next;
        pq_reg <= pq_next; rq_reg <= rq_next; pv_reg <= pv_next; rv_reg <= rv_next;
        oi_reg <= oi_next; os_reg <= os_next;
        op_reg <= op_next; opv_reg <= opv_next; or_reg <= or_next; orv_reg <= orv_next;
        of_reg <= of_next; ofv_reg <= ofv_next;
    end

    assign out_valid       = ov_reg;
    assign class_index     = oi_reg;
    assign is_summary      = os_reg;
    assign precision_q16   = op_reg;
    assign precision_valid = opv_reg;
    assign recall_q16      = or_reg;
    assign recall_valid    = orv_reg;
    assign fscore_q16      = of_reg;
    assign fscore_valid    = ofv_reg;
    assign last_result     = os_reg;
endmodule

FILE: test/cmpr_checker.sv
module cmpr_checker import cmpr_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [CMPR_IDX_BITS-1:0]  true_class,
    input  logic [CMPR_IDX_BITS-1:0]  pred_class,
    input  logic                      last_sample,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CMPR_NC_BITS-1:0]   cfg_data,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [CMPR_IDX_BITS-1:0]  class_index,
    input  logic                      is_summary,
    input  logic [CMPR_FRAC_BITS:0]   precision_q16,
    input  logic                      precision_valid,
    input  logic [CMPR_FRAC_BITS:0]   recall_q16,
    input  logic                      recall_valid,
    input  logic [CMPR_FRAC_BITS:0]   fscore_q16,
    input  logic                      fscore_valid,
    input  logic                      last_result,
    output int                        errors,
    output int                        pending
);

    localparam int QW = CMPR_FRAC_BITS + 1;
    localparam longint CNT_MAX = (64'd1 << CMPR_COUNT_BITS) - 1;

    typedef struct packed {
        logic [CMPR_IDX_BITS-1:0] cls;
        logic                     summ;
        logic [QW-1:0]            prec;
        logic                     prec_ok;
        logic [QW-1:0]            rec;
        logic                     rec_ok;
        logic [QW-1:0]            fsc;
        logic                     fsc_ok;
        logic                     fin;
    } score_t;

    longint counts [CMPR_CLASSES][CMPR_CLASSES];
    logic [CMPR_NC_BITS-1:0] nc_reg;
    score_t score_q[$];

    function automatic int class_count();
        if (nc_reg < 2) return 2;
        if (nc_reg > CMPR_CLASSES) return CMPR_CLASSES;
        return int'(nc_reg);
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // count one sample; on the last one, push per-class scores and the summary, then clear the counts
    task automatic count_sample(input logic [3:0] t, input logic [3:0] p, input logic l);
        int n;
        longint col, row, d, pq, rq, psum, rsum, pdef, rdef, ap, ar, f;
        score_t s;
        n = class_count();
        psum = 0; rsum = 0; pdef = 0; rdef = 0;
        if (t < n && p < n && counts[t][p] < CNT_MAX) counts[t][p]++;
        if (!l) return;
        for (int i = 0; i < n; i++)
        begin
            col = 0; row = 0; d = counts[i][i];
            for (int j = 0; j < n; j++)
            begin
                col += counts[j][i];
                row += counts[i][j];
            end
            s = '0;
            s.cls = CMPR_IDX_BITS'(i);
            if (col != 0)
            begin
                pq = (d << CMPR_FRAC_BITS) / col;
                s.prec = QW'(pq); s.prec_ok = 1; psum += pq; pdef++;
            end
            if (row != 0)
            begin
                rq = (d << CMPR_FRAC_BITS) / row;
                s.rec = QW'(rq); s.rec_ok = 1; rsum += rq; rdef++;
            end
            score_q.push_back(s);
        end
        s = '0;
        s.summ = 1;
        s.fin = 1;
        ap = 0; ar = 0;
        if (pdef != 0) begin ap = psum / pdef; s.prec = QW'(ap); s.prec_ok = 1; end
        if (rdef != 0) begin ar = rsum / rdef; s.rec = QW'(ar); s.rec_ok = 1; end
        if (s.prec_ok && s.rec_ok && (ap + ar) != 0)
        begin
            f = (2 * ap * ar) / (ap + ar);
            s.fsc = QW'(f); s.fsc_ok = 1;
        end
        score_q.push_back(s);
        for (int i = 0; i < CMPR_CLASSES; i++)
            for (int j = 0; j < CMPR_CLASSES; j++)
                counts[i][j] = 0;
    endtask

    // watch all channels
    always @(posedge clk or negedge rst_n)
    begin
        score_t e;
        if (!rst_n)
        begin
            errors = 0;
            nc_reg = 2;
            score_q.delete();
            for (int i = 0; i < CMPR_CLASSES; i++)
                for (int j = 0; j < CMPR_CLASSES; j++)
                    counts[i][j] = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) nc_reg = cfg_data;
            if (in_valid && !in_stall) count_sample(true_class, pred_class, last_sample);
            if (out_valid && !out_stall)
            begin
                if (score_q.size() == 0)
                begin
                    report("unexpected result word, class_index", class_index, -1);
                end
                else
                begin
                    e = score_q.pop_front();
                    if (class_index != e.cls) report("class_index", class_index, e.cls);
                    if (is_summary != e.summ) report("is_summary", is_summary, e.summ);
                    if (precision_q16 != e.prec) report("precision", precision_q16, e.prec);
                    if (precision_valid != e.prec_ok)
                        report("precision_valid", precision_valid, e.prec_ok);
                    if (recall_q16 != e.rec) report("recall", recall_q16, e.rec);
                    if (recall_valid != e.rec_ok) report("recall_valid", recall_valid, e.rec_ok);
                    if (fscore_q16 != e.fsc) report("fscore", fscore_q16, e.fsc);
                    if (fscore_valid != e.fsc_ok) report("fscore_valid", fscore_valid, e.fsc_ok);
                    if (last_result != e.fin) report("last_result", last_result, e.fin);
                end
            end
        end
        pending = score_q.size();
    end

endmodule

FILE: test/tb_confusion_matrix_precision_recall.sv
module tb_confusion_matrix_precision_recall;
    import cmpr_pkg::*;

    localparam int QW = CMPR_FRAC_BITS + 1;
    localparam int CYCLE_LIMIT = 2000000;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [CMPR_IDX_BITS-1:0] true_class = 0;
    logic [CMPR_IDX_BITS-1:0] pred_class = 0;
    logic last_sample = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CMPR_NC_BITS-1:0] cfg_data = 0;
    logic out_valid;
    logic out_stall = 0;
    logic [CMPR_IDX_BITS-1:0] class_index;
    logic is_summary, precision_valid, recall_valid, fscore_valid, last_result;
    logic [QW-1:0] precision_q16, recall_q16, fscore_q16;
    int errors, pending;
    int cycles = 0;
    bit calm = 0;          // no idling on either side
    bit hold_req = 0;      // ask the receiver for one long hold-off
    bit hold_done = 0;
    int hold_cycles = 0;   // hold-off cycles still to go

    always #5 clk = ~clk;

    confusion_matrix_precision_recall dut (.*);

    cmpr_checker chk (.*);

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL confusion_matrix_precision_recall");
            $finish;
        end
    end

    // receiver stall: random, calm, or a long hold-off
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done <= 1;
            hold_cycles <= 400;
            out_stall <= 1;
        end
        else if (hold_cycles > 0)
        begin
            out_stall <= 1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < 24);
    end

    // offer one word, with a random gap before it
    task automatic send_word(input logic [3:0] t, input logic [3:0] p, input logic l);
        while (!calm && $urandom_range(99) < 24)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        true_class <= t;
        pred_class <= p;
        last_sample <= l;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_classes(input logic [4:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
    endtask

    // one labelled set: mostly in range, last word ends it
    task automatic send_set(input int len, input int nc);
        int lim;
        lim = (nc < 2) ? 2 : (nc > 16 ? 16 : nc);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                send_word(4'($urandom), 4'($urandom), i == len - 1);
            else if ($urandom_range(2) == 0)
                begin
                    int c;
                    c = $urandom_range(lim - 1);
                    send_word(4'(c), 4'(c), i == len - 1);
                end
            else
                send_word(4'($urandom_range(lim - 1)), 4'($urandom_range(lim - 1)),
                          i == len - 1);
        end
    endtask

    initial
    begin
        int nc;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: default size, extremes, out of range, empty-ish sets
        send_word(0, 0, 0);
        send_word(1, 1, 0);
        send_word(1, 0, 0);
        send_word(15, 15, 0);
        send_word(0, 15, 1);
        send_word(15, 0, 1);           // nothing counted: all undefined
        send_word(0, 1, 1);            // one off-diagonal: fscore undefined
        drain();
        write_classes(16);
        send_word(15, 15, 0);
        send_word(15, 14, 0);
        send_word(7, 7, 0);
        send_word(10, 5, 1);
        drain();
        write_classes(0);              // acts as two
        send_word(1, 1, 0);
        send_word(0, 1, 0);
        send_word(2, 2, 1);
        drain();
        write_classes(31);             // acts as sixteen
        send_word(15, 15, 1);
        drain();

        // random sets under varied sizes
        for (int ph = 0; ph < 8; ph++)
        begin
            nc = (ph == 0) ? 2 : (ph == 1 ? 16 : $urandom_range(31));
            write_classes(5'(nc));
            calm = (ph == 3);
            if (ph == 5) hold_req = 1;   // block fills and stalls input
            send_set($urandom_range(4, 16), nc);
            send_set($urandom_range(2, 8), nc);
            drain();
        end
        calm = 0;

        if (errors == 0)
            $display("PASS confusion_matrix_precision_recall");
        else
            $display("FAIL confusion_matrix_precision_recall");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/cmpr_pkg.sv
hw/rtl/cmpr_div.sv
hw/rtl/confusion_matrix_precision_recall.sv
test/cmpr_checker.sv
test/tb_confusion_matrix_precision_recall.sv
